/* design/swgd_pkg.sv */
// Package for the sliding-window genetic distance block.
// Holds field widths, ring geometry, register indexes, mode and state codes.
// No dependencies.
package swgd_pkg;
	localparam int MAX_WINDOW = 1024;
	localparam int FREQ_BITS  = 16;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int POS_W      = 32;
	localparam int FREQ_W     = FREQ_BITS + 1;
	localparam int VAL_W      = FREQ_BITS + 2;
	localparam int SUM_W      = VAL_W + ADDR_W;
	localparam int MAG_W      = SUM_W - 1;
	localparam int IDX_W      = 3;
	localparam int MODE_W     = 2;

	localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEP     = 3'd2;
	localparam logic [IDX_W-1:0] REG_BASELINE = 3'd3;

	localparam logic [MODE_W-1:0] MODE_REGIONAL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INDIV_BASE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WEIGHTED   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALIAS      = 2'd3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CAP   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;
	localparam logic [2:0] ST_SLIDE = 3'd5;
endpackage

/* design/sliding_window_genetic_distance.sv */
// Top level of the sliding-window genetic distance block: ring memories,
// running window sum, serial divider and slide sequencer. Uses swgd_pkg.
//
//  channel | signals                                   | role
//  in      | in_valid/in_ready, position..end_of_stream | one site per item
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | register writes
//  out     | out_valid/out_ready, window_start..partial | one window per item
//
// A site that closes no window leaves the sequencer idle. A closing site
// passes the start read, the bit-serial divider and the output register,
// then, unless the stream ended, retires the oldest step sites through the
// single memory read port. Reset clears ring pointers, sums, mode and
// baseline, sets window and step to one; memories need no clearing. The
// output register holds a result while another site is accepted. Registers
// are written only while idle, and a pending write holds off the next site.
module sliding_window_genetic_distance (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [swgd_pkg::POS_W-1:0]      position,
	input  logic [1:0]                      genotype_a,
	input  logic [1:0]                      genotype_b,
	input  logic [swgd_pkg::FREQ_W-1:0]     freq_pop1,
	input  logic [swgd_pkg::FREQ_W-1:0]     freq_pop2,
	input  logic                            end_of_stream,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swgd_pkg::IDX_W-1:0]      cfg_index,
	input  logic [swgd_pkg::FREQ_W-1:0]     cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [swgd_pkg::POS_W-1:0]      window_start,
	output logic [swgd_pkg::POS_W-1:0]      window_stop,
	output logic [swgd_pkg::POS_W-1:0]      midpoint,
	output logic signed [swgd_pkg::VAL_W-1:0] statistic,
	output logic [swgd_pkg::CNT_W-1:0]      sites_with_data,
	output logic                            partial_window
);
	import swgd_pkg::*;

	localparam logic [FREQ_W-1:0] ONE_Q = FREQ_W'(1) << FREQ_BITS;
	localparam logic [CNT_W-1:0]  MAXW  = CNT_W'(MAX_WINDOW);

	logic [POS_W-1:0]   pos_mem [MAX_WINDOW];
	logic [VAL_W:0]     val_mem [MAX_WINDOW];
	logic [POS_W-1:0]   pos_rd_q;
	logic [VAL_W:0]     val_rd_q;
	logic [ADDR_W-1:0]  raddr;
	logic               we;
	logic [ADDR_W-1:0]  waddr;

	logic [MODE_W-1:0]  mode_q;
	logic [CNT_W-1:0]   wsize_q, ssize_q;
	logic [FREQ_W-1:0]  baseline_q;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   fill_q, cnt_q, k_q;
	logic [ADDR_W-1:0]  head_q;
	logic signed [SUM_W-1:0] sum_q;
	logic               eos_q, partial_q, neg_q, rd_vld_s1;
	logic [POS_W-1:0]   start_q, stop_q;
	logic [MAG_W-1:0]   dvd_q;
	logic [ADDR_W:0]    rem_q;
	logic [4:0]         bit_q;
	logic [CNT_W-1:0]   n_q;

	logic [CNT_W-1:0]   w_eff, s_eff, fill_new;
	logic [FREQ_W-1:0]  p1, p2, ga_s, gb_s;
	logic [FREQ_W-1:0]  a_d, b_d, c_d;
	logic [FREQ_W:0]    ab;
	logic signed [VAL_W-1:0] value;
	logic               site_ok;
	logic               accept;
	logic [ADDR_W+1:0]  trial;
	logic signed [VAL_W:0] mean_s, stat_full;

	always_comb begin
		w_eff = wsize_q;
		if (wsize_q == '0) w_eff = CNT_W'(1);
		if (wsize_q > MAXW) w_eff = MAXW;
		s_eff = (ssize_q == '0) ? CNT_W'(1) : ssize_q;
		if (s_eff > w_eff) s_eff = w_eff;
	end

	// Per-site distance; genotypes scale to g * ONE / 2.
	always_comb begin
		p1 = (freq_pop1 > ONE_Q) ? ONE_Q : freq_pop1;
		p2 = (freq_pop2 > ONE_Q) ? ONE_Q : freq_pop2;
		ga_s = FREQ_W'(genotype_a) << (FREQ_BITS - 1);
		gb_s = FREQ_W'(genotype_b) << (FREQ_BITS - 1);
		a_d = (ga_s > p1) ? ga_s - p1 : p1 - ga_s;
		b_d = (gb_s > p2) ? gb_s - p2 : p2 - gb_s;
		c_d = (ga_s > p2) ? ga_s - p2 : p2 - ga_s;
		ab = {1'b0, a_d} + {1'b0, b_d};
		value = '0;
		if (mode_q inside {MODE_WEIGHTED, MODE_ALIAS}) begin
			site_ok = (genotype_a != 2'd3) && (genotype_b != 2'd3);
			if (genotype_a == genotype_b) value = VAL_W'(ab >> 1);
			else if ((genotype_a ^ genotype_b) != 2'd2 && genotype_a != 2'd1 &&
				genotype_b != 2'd1) value = '0;
			else if (genotype_a == 2'd1 || genotype_b == 2'd1) value = VAL_W'(ab >> 2);
		end else begin
			site_ok = genotype_a != 2'd3;
			value = $signed({1'b0, c_d});
			if (mode_q == MODE_REGIONAL) begin
				value = $signed({1'b0, c_d}) - $signed({1'b0, ((p1 > p2) ? p1 - p2 : p2 - p1)});
			end
		end
		if (!site_ok) value = '0;
	end

	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign fill_new  = fill_q + CNT_W'(1);
	assign we        = accept;
	assign waddr     = head_q + fill_q[ADDR_W-1:0];

	always_comb begin
		raddr = head_q;
		if (state_q == ST_SLIDE) raddr = head_q + k_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			pos_mem[waddr] <= position;
			val_mem[waddr] <= {site_ok, value};
		end
		pos_rd_q <= pos_mem[raddr];
		val_rd_q <= val_mem[raddr];
	end

	assign trial = {rem_q, dvd_q[MAG_W-1]};
	assign mean_s = (n_q == '0) ? '0 :
		(neg_q ? -$signed({2'b0, dvd_q[FREQ_W-1:0]}) : $signed({2'b0, dvd_q[FREQ_W-1:0]}));
	assign stat_full = mean_s - ((mode_q == MODE_INDIV_BASE) ?
		$signed({2'b0, baseline_q}) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; wsize_q <= CNT_W'(1); ssize_q <= CNT_W'(1); baseline_q <= '0;
			state_q <= ST_IDLE; fill_q <= '0; cnt_q <= '0; head_q <= '0; sum_q <= '0;
			k_q <= '0; rd_vld_s1 <= 1'b0; out_valid <= 1'b0; eos_q <= 1'b0;
			partial_q <= 1'b0; bit_q <= '0;
		end else begin
			// A result leaving in the output state is replaced there.
			if (out_valid && out_ready && state_q != ST_OUT) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:     mode_q <= cfg_data[MODE_W-1:0];
					REG_WINDOW:   wsize_q <= cfg_data[CNT_W-1:0];
					REG_STEP:     ssize_q <= cfg_data[CNT_W-1:0];
					REG_BASELINE: baseline_q <= cfg_data;
					default: ;
				endcase
				if (cfg_index == REG_MODE || cfg_index == REG_WINDOW ||
					cfg_index == REG_STEP) begin
					fill_q <= '0; head_q <= '0; sum_q <= '0; cnt_q <= '0;
				end
			end
			case (state_q)
				ST_IDLE: if (accept) begin
					stop_q <= position;
					eos_q <= end_of_stream;
					partial_q <= fill_new < w_eff;
					if (fill_new >= w_eff || (end_of_stream && fill_new > w_eff - s_eff)) begin
						sum_q <= sum_q + SUM_W'(value);
						cnt_q <= cnt_q + CNT_W'(site_ok);
						fill_q <= fill_new;
						state_q <= ST_RD;
					end else if (end_of_stream) begin
						fill_q <= '0; head_q <= '0; sum_q <= '0; cnt_q <= '0;
					end else begin
						sum_q <= sum_q + SUM_W'(value);
						cnt_q <= cnt_q + CNT_W'(site_ok);
						fill_q <= fill_new;
					end
				end
				ST_RD: begin
					neg_q <= sum_q[SUM_W-1];
					dvd_q <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
					rem_q <= '0;
					n_q <= cnt_q;
					bit_q <= 5'(MAG_W);
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					start_q <= pos_rd_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// One quotient bit a cycle, shifted into the dividend register.
					if (trial >= {1'b0, n_q}) begin
						rem_q <= (ADDR_W+1)'(trial - {1'b0, n_q});
						dvd_q <= {dvd_q[MAG_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[ADDR_W:0];
						dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd1) state_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					window_start <= start_q;
					window_stop <= stop_q;
					midpoint <= POS_W'(({1'b0, start_q} + {1'b0, stop_q}) >> 1);
					statistic <= VAL_W'(stat_full);
					sites_with_data <= n_q;
					partial_window <= partial_q;
					k_q <= '0;
					if (eos_q) begin
						fill_q <= '0; head_q <= '0; sum_q <= '0; cnt_q <= '0;
						state_q <= ST_IDLE;
					end else state_q <= ST_SLIDE;
				end
				ST_SLIDE: begin
					// Oldest sites leave the running sum as their reads return.
					rd_vld_s1 <= k_q < s_eff;
					if (k_q < s_eff) k_q <= k_q + CNT_W'(1);
					if (rd_vld_s1 && val_rd_q[VAL_W]) begin
						sum_q <= sum_q - SUM_W'($signed(val_rd_q[VAL_W-1:0]));
						cnt_q <= cnt_q - CNT_W'(1);
					end
					if (k_q == s_eff && !rd_vld_s1) begin
						head_q <= head_q + s_eff[ADDR_W-1:0];
						fill_q <= w_eff - s_eff;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= MAXW)
		else $error("fill count beyond ring depth");
	a_cnt_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> cnt_q <= fill_q)
		else $error("data count exceeds held sites");
	a_sum_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cnt_q == '0) |-> sum_q == '0)
		else $error("running sum not zero with no sites");
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sites_with_data <= MAXW)
		else $error("result count beyond window");
`endif
endmodule
